// ----- rtl/ssra_pkg.sv -----
package ssra_pkg;

   localparam int unsigned IDX_W    = 12;
   localparam int unsigned STATUS_W = 2;
   localparam int unsigned CSR_W    = 13;

   // busy map row width; a run may straddle two rows
   localparam int unsigned WORD_BITS = 64;

   localparam logic [CSR_W-1:0] CSR_RESET = 13'd4096;

   localparam logic OP_ALLOC   = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_NO_SPACE = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_RANGE    = 2'd2;

   typedef struct packed {
      logic             op;
      logic [IDX_W-1:0] sector_index;
   } req_type;

   typedef struct packed {
      logic [IDX_W-1:0]    slot_index;
      logic [STATUS_W-1:0] status;
   } rsp_type;

   typedef logic [CSR_W-1:0] csr_type;

endpackage

// ----- rtl/ssra_chan_if.sv -----
interface ssra_chan_if #(
   parameter type data_type = logic
) ();

   logic     valid;
   logic     ready;
   data_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);

endinterface

// ----- rtl/ssra_map_ram.sv -----
module ssra_map_ram #(
   parameter int unsigned WORDS = 64,
   parameter int unsigned WB    = 64,
   parameter int unsigned AW    = 6
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [WB-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [WB-1:0] rd_data
);

   logic [WB-1:0] mem [WORDS];
   logic [WB-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/swap_slot_run_allocator.sv -----
// First-fit allocator of sector runs over a busy map held in a 64-bit-wide
// RAM. An allocate scans the map one row per cycle, from row 0 up to the
// row that holds the sector limit (min of the CSR value and SECTORS), and
// then posts the result; the scan rate is set by the single RAM read port.
// A release does a read-modify-write of one or two rows; an out-of-range
// release answers with a range status and leaves the map as it is. One
// request is in flight at a time; a new one is taken while the previous
// result still waits on rsp. After reset a clearing pass writes every row
// free, during which req is not ready.
module swap_slot_run_allocator #(
   parameter int unsigned SECTORS    = 4096,
   parameter int unsigned RUN_LENGTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   ssra_chan_if.sink   req_if,
   ssra_chan_if.source rsp_if,
   ssra_chan_if.sink   csr_if
);

   localparam int unsigned WB    = ssra_pkg::WORD_BITS;
   localparam int unsigned WORDS = (SECTORS + WB - 1) / WB;
   localparam int unsigned WAW   = (WORDS > 1) ? $clog2(WORDS) : 1;
   localparam int unsigned PW    = $clog2(WB);
   localparam int unsigned SUMW  = $clog2(SECTORS + 8192 + 2 * WB) + 1;
   localparam int unsigned EXTW  = WB + RUN_LENGTH;
   localparam int unsigned IDX_W = ssra_pkg::IDX_W;

   localparam logic [2:0] S_CLEAR      = 3'd0;
   localparam logic [2:0] S_IDLE       = 3'd1;
   localparam logic [2:0] S_SCAN       = 3'd2;
   localparam logic [2:0] S_ALLOC_PREV = 3'd3;
   localparam logic [2:0] S_REL_A      = 3'd4;
   localparam logic [2:0] S_REL_B      = 3'd5;
   localparam logic [2:0] S_POST       = 3'd6;

   logic [2:0]     state_ff, state_in;
   logic [WAW-1:0] word_ff, word_in;
   logic [WB-1:0]  prev_word_ff, prev_word_in;
   logic [WB-1:0]  prev_mask_ff, prev_mask_in;
   logic [WB-1:0]  rel_lo_ff, rel_lo_in;
   logic [WB-1:0]  rel_hi_ff, rel_hi_in;
   logic           rel_two_ff, rel_two_in;
   logic [IDX_W-1:0]              res_slot_ff, res_slot_in;
   logic [ssra_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   ssra_pkg::csr_type csr_ff, csr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   ssra_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic           wr_en;
   logic [WAW-1:0] wr_addr;
   logic [WB-1:0]  wr_data;
   logic [WB-1:0]  rd_data;

   logic [SUMW-1:0] limit;
   logic [SUMW-1:0] base;
   logic [SUMW-1:0] avail;
   logic [WB-1:0]   lim_mask;
   logic [EXTW-1:0] ext;
   logic [WB-1:0]   ok;
   logic [WB-1:0]   hit;
   logic            found;
   logic [PW-1:0]   pos;
   logic [EXTW-1:0] run_ext;
   logic [WB-1:0]   cur_mask;
   logic [WB-1:0]   prev_mask;
   logic [SUMW-1:0] slot_calc;
   logic            last_word;

   ssra_pkg::req_type req;
   logic              req_xfer;
   logic [SUMW-1:0]   rel_end;
   logic              rel_bad;
   logic [2*WB-1:0]   rel_ext;

   ssra_map_ram #(
      .WORDS (WORDS),
      .WB    (WB),
      .AW    (WAW)
   ) u_map (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (word_in),
      .rd_data (rd_data)
   );

   assign csr_if.ready = 1'b1;
   assign csr_in = csr_if.valid ? csr_if.data : csr_ff;

   assign req          = req_if.data;
   assign req_if.ready = (state_ff == S_IDLE);
   assign req_xfer     = req_if.valid && req_if.ready;

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   always_comb begin
      if (SUMW'(csr_ff) > SUMW'(SECTORS)) begin
         limit = SUMW'(SECTORS);
      end else begin
         limit = SUMW'(csr_ff);
      end
   end

   // row evaluation: free bits of this row plus the top of the previous row
   assign base  = SUMW'({word_ff, {PW{1'b0}}});
   assign avail = limit - base;

   always_comb begin
      if (limit >= base + SUMW'(WB)) begin
         lim_mask = {WB{1'b1}};
      end else if (limit <= base) begin
         lim_mask = '0;
      end else begin
         lim_mask = ~({WB{1'b1}} << avail[PW-1:0]);
      end
   end

   assign ext = {~rd_data, ~prev_word_ff[WB-1 -: RUN_LENGTH]};

   always_comb begin
      for (int p = 0; p < WB; p++) begin
         ok[p] = &ext[p + 1 +: RUN_LENGTH];
      end
   end

   assign hit   = ok & lim_mask;
   assign found = |hit;

   always_comb begin
      pos = '0;
      for (int p = WB - 1; p >= 0; p--) begin
         if (hit[p]) begin
            pos = PW'(p);
         end
      end
   end

   assign run_ext   = EXTW'({RUN_LENGTH{1'b1}}) << ({1'b0, pos} + (PW + 1)'(1));
   assign cur_mask  = run_ext[EXTW-1 -: WB];
   assign prev_mask = WB'(run_ext[RUN_LENGTH-1:0]) << (WB - RUN_LENGTH);
   assign slot_calc = base + SUMW'(pos) + SUMW'(1) - SUMW'(RUN_LENGTH);
   assign last_word = (base + SUMW'(WB)) >= limit;

   assign rel_end = SUMW'(req.sector_index) + SUMW'(RUN_LENGTH);
   assign rel_bad = rel_end > limit;
   assign rel_ext = (2 * WB)'({RUN_LENGTH{1'b1}}) << req.sector_index[PW-1:0];

   always_comb begin
      state_in      = state_ff;
      word_in       = word_ff;
      prev_word_in  = prev_word_ff;
      prev_mask_in  = prev_mask_ff;
      rel_lo_in     = rel_lo_ff;
      rel_hi_in     = rel_hi_ff;
      rel_two_in    = rel_two_ff;
      res_slot_in   = res_slot_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = '0;

      unique case (state_ff)
         S_CLEAR: begin
            wr_en = 1'b1;
            if (word_ff == WAW'(WORDS - 1)) begin
               word_in  = '0;
               state_in = S_IDLE;
            end else begin
               word_in = word_ff + WAW'(1);
            end
         end
         S_IDLE: begin
            if (req_xfer) begin
               res_slot_in   = '0;
               res_status_in = ssra_pkg::STATUS_DONE;
               if (req.op == ssra_pkg::OP_ALLOC) begin
                  word_in      = '0;
                  prev_word_in = {WB{1'b1}};
                  state_in     = S_SCAN;
               end else if (rel_bad) begin
                  res_status_in = ssra_pkg::STATUS_RANGE;
                  state_in      = S_POST;
               end else begin
                  word_in    = WAW'(req.sector_index >> PW);
                  rel_lo_in  = rel_ext[WB-1:0];
                  rel_hi_in  = rel_ext[2*WB-1:WB];
                  rel_two_in = |rel_ext[2*WB-1:WB];
                  state_in   = S_REL_A;
               end
            end
         end
         S_SCAN: begin
            if (found) begin
               wr_en        = 1'b1;
               wr_data      = rd_data | cur_mask;
               prev_mask_in = prev_mask;
               res_slot_in  = slot_calc[IDX_W-1:0];
               state_in     = (|prev_mask) ? S_ALLOC_PREV : S_POST;
            end else if (last_word) begin
               res_status_in = ssra_pkg::STATUS_NO_SPACE;
               state_in      = S_POST;
            end else begin
               // advance one row, keep this one for runs that straddle
               word_in      = word_ff + WAW'(1);
               prev_word_in = rd_data;
            end
         end
         S_ALLOC_PREV: begin
            wr_en    = 1'b1;
            wr_addr  = word_ff - WAW'(1);
            wr_data  = prev_word_ff | prev_mask_ff;
            state_in = S_POST;
         end
         S_REL_A: begin
            wr_en    = 1'b1;
            wr_data  = rd_data & ~rel_lo_ff;
            word_in  = word_ff + WAW'(1);
            state_in = rel_two_ff ? S_REL_B : S_POST;
         end
         S_REL_B: begin
            wr_en    = 1'b1;
            wr_data  = rd_data & ~rel_hi_ff;
            state_in = S_POST;
         end
         S_POST: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in           = 1'b1;
               rsp_data_in.slot_index = res_slot_ff;
               rsp_data_in.status     = res_status_ff;
               state_in               = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         word_ff      <= '0;
         csr_ff       <= ssra_pkg::CSR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         csr_ff       <= csr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_word_ff  <= prev_word_in;
      prev_mask_ff  <= prev_mask_in;
      rel_lo_ff     <= rel_lo_in;
      rel_hi_ff     <= rel_hi_in;
      rel_two_ff    <= rel_two_in;
      res_slot_ff   <= res_slot_in;
      res_status_ff <= res_status_in;
      rsp_data_ff   <= rsp_data_in;
   end

endmodule
